[src/i2cmbe_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Item types, command codes and small helper functions shared by the engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5
    } cmd_t;

    localparam int LEN_W   = 16;
    localparam int STEP_W  = 5;
    localparam int BYTE_W  = 8;

    // Last phase of a write: SCL is pulled low after the eighth bit.
    localparam logic [STEP_W-1:0] WRITE_TAIL_STEP = 5'd24;
    // Last SCL-high phase of a read in which a data bit is sampled.
    localparam logic [STEP_W-1:0] READ_LAST_SAMPLE = 5'd16;

    typedef struct packed {
        logic [2:0]        kind;
        logic [BYTE_W-1:0] data;
        logic              sda_in;
    } in_item_t;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              nack;
    } out_item_t;

    // Number of bus phases in each command.
    function automatic logic [STEP_W-1:0] phase_count(input cmd_t cmd);
        logic [STEP_W-1:0] n;
        case (cmd)
            CMD_START: n = 5'd4;
            CMD_STOP:  n = 5'd3;
            CMD_WRITE: n = 5'd25;
            CMD_READ:  n = 5'd20;
            CMD_ACK:   n = 5'd5;
            default:   n = 5'd1;
        endcase
        return n;
    endfunction

    // Remainder of a step number by three, by folding the bit weights.
    function automatic logic [1:0] step_mod3(input logic [STEP_W-1:0] step);
        logic [2:0] s;
        s = 3'(step[0]) + 3'(step[2]) + 3'(step[4])
          + {1'b0, step[1], 1'b0} + {1'b0, step[3], 1'b0};
        if (s >= 3'd6)
            s = s - 3'd6;
        else if (s >= 3'd3)
            s = s - 3'd3;
        return s[1:0];
    endfunction

endpackage

[src/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven generator of I2C start, stop, byte and acknowledge phases.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel is one tick of bus time: it carries the
// sampled SDA level and, while the engine is idle, an optional command.
// Every item yields exactly one result item on the m_ channel, giving the
// SCL and SDA pin controls, busy and done flags, the last read byte and the
// last acknowledge sample.
// An item passes an input register, the phase logic and a result register
// before its result is presented on m_item.
// One item is accepted every cycle while the receiver does not stall; the
// figure is set by the single pass through the phase logic.
// When the receiver stalls, the result register holds its item and the
// input register takes one more; after that s_ready falls until m_ready
// returns, and no item is lost.
// The user writes phase_len via cfg_wr_en/cfg_wr_data only while the engine
// is idle; the block does not enforce this. Reset returns the engine to idle
// with SCL high, SDA driven high, phase_len at one tick, both channels empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    logic             in_valid_reg, in_valid_next;
    in_item_t         in_item_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg;
    logic [LEN_W-1:0] phase_len_reg;
    logic             advance;
    out_item_t        result;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (advance)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    i2cmbe_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (in_item_reg),
        .phase_len (phase_len_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            phase_len_reg <= LEN_W'(1);
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en)
                phase_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_item_reg <= s_item;
        if (advance)
            m_item_reg <= result;
    end

endmodule

[src/i2cmbe_engine.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Holds the bus phase state and works out one tick per advanced item.
// ----------------------------------------------------------------------------
module i2cmbe_engine
    import i2cmbe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  in_item_t         item,
    input  logic [LEN_W-1:0] phase_len,
    output out_item_t        result
);

    cmd_t              cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  tick_reg, tick_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] rd_reg, rd_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              en_reg, en_next;
    logic              nack_reg, nack_next;

    cmd_t              cmd;
    logic              launch, active, last_tick, finished;
    logic [STEP_W-1:0] step, step_inc;
    logic [LEN_W-1:0]  tick, len_m1;
    logic [BYTE_W-1:0] shift_e;
    logic [1:0]        wmod;

    always_comb begin
        launch = (cmd_reg == CMD_IDLE) && (item.kind inside {[CMD_START:CMD_ACK]});
        cmd    = launch ? cmd_t'(item.kind) : cmd_reg;
        step   = launch ? '0 : step_reg;
        tick   = launch ? '0 : tick_reg;
        active = (cmd != CMD_IDLE);
        wmod   = step_mod3(step);
        len_m1 = (phase_len == '0) ? '0 : phase_len - 1'b1;
        last_tick = (tick >= len_m1);
        step_inc  = step + 1'b1;
        finished  = (step_inc >= phase_count(cmd));
    end

    // Pin levels and shift register after entering the phase.
    always_comb begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        en_next  = en_reg;
        shift_e  = launch ? ((cmd == CMD_WRITE) ? item.data : '0) : shift_reg;
        if (active && tick == '0) begin
            case (cmd)
                CMD_START: begin
                    case (step)
                        5'd0:    scl_next = 1'b1;
                        5'd1:    begin sda_next = 1'b1; en_next = 1'b1; end
                        5'd2:    begin sda_next = 1'b0; en_next = 1'b1; end
                        default: scl_next = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (step)
                        5'd0:    begin sda_next = 1'b0; en_next = 1'b1; end
                        5'd1:    scl_next = 1'b1;
                        default: begin sda_next = 1'b1; en_next = 1'b1; end
                    endcase
                end
                CMD_WRITE: begin
                    if (step >= WRITE_TAIL_STEP || wmod == 2'd0) begin
                        scl_next = 1'b0;
                    end else if (wmod == 2'd1) begin
                        sda_next = shift_e[BYTE_W-1];
                        en_next  = 1'b1;
                        shift_e  = {shift_e[BYTE_W-2:0], 1'b0};
                    end else begin
                        scl_next = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (step == 5'd0) begin
                        scl_next = 1'b0;
                    end else if (step == 5'd1) begin
                        sda_next = 1'b1;
                        en_next  = 1'b0;
                    end else begin
                        scl_next = ~step[0];
                    end
                end
                CMD_ACK: begin
                    case (step)
                        5'd0:    scl_next = 1'b0;
                        5'd1:    begin sda_next = 1'b1; en_next = 1'b1; end
                        5'd2:    begin en_next = 1'b0; scl_next = 1'b1; end
                        5'd4:    scl_next = 1'b0;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Sampling at the end of a phase and the step bookkeeping.
    always_comb begin
        cmd_next   = cmd;
        step_next  = step;
        tick_next  = tick;
        shift_next = shift_e;
        rd_next    = rd_reg;
        nack_next  = nack_reg;
        if (active) begin
            if (last_tick) begin
                if (cmd == CMD_READ && step >= 5'd2 && step <= READ_LAST_SAMPLE
                    && !step[0])
                    shift_next = {shift_e[BYTE_W-2:0], item.sda_in};
                else if (cmd == CMD_ACK && step == 5'd2)
                    nack_next = item.sda_in;
                tick_next = '0;
                if (finished) begin
                    if (cmd == CMD_READ)
                        rd_next = shift_next;
                    cmd_next  = CMD_IDLE;
                    step_next = '0;
                end else begin
                    step_next = step_inc;
                end
            end else begin
                tick_next = tick + 1'b1;
            end
        end
    end

    always_comb begin
        result.scl       = scl_next;
        result.sda_out   = sda_next;
        result.sda_drive = en_next;
        result.busy_res  = active;
        result.done_res  = active && last_tick && finished;
        result.read_byte = rd_next;
        result.nack      = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            step_reg  <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            rd_reg    <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            en_reg    <= 1'b1;
            nack_reg  <= 1'b0;
        end else if (advance) begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            rd_reg    <= rd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            en_reg    <= en_next;
            nack_reg  <= nack_next;
        end
    end

endmodule

[bench/i2c_master_bit_engine_tb.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Sends bus ticks carrying start, stop, write, read and acknowledge commands,
// predicts the pin and status item for every tick, and checks each result
// against the prediction under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    import i2cmbe_pkg::*;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_item = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_item;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    // Predicted engine state, as left after reset.
    logic [15:0] eng_len   = 16'd1;
    logic [4:0]  eng_step  = '0;
    logic [15:0] eng_count = '0;
    cmd_t        eng_cmd   = CMD_IDLE;
    logic [7:0]  eng_shift = '0;
    logic [7:0]  eng_rd    = '0;
    logic        eng_scl   = 1'b1;
    logic        eng_sda   = 1'b1;
    logic        eng_oe    = 1'b1;
    logic        eng_nack  = 1'b0;

    in_item_t  tick_queue [$];
    out_item_t pins_due [$];
    int        items_queued = 0;
    int        items_taken = 0;
    int        results_seen = 0;
    int        fail_count = 0;
    int        cmds_begun [8];
    bit        s_took = 1'b0;
    bit        idling_on = 1'b1;
    int        gap_left = 0;
    int        stall_left = 0;

    i2c_master_bit_engine uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int phases_of(cmd_t op);
        int n;
        case (op)
            CMD_START: n = 4;
            CMD_STOP:  n = 3;
            CMD_WRITE: n = 25;
            CMD_READ:  n = 20;
            CMD_ACK:   n = 5;
            default:   n = 1;
        endcase
        return n;
    endfunction

    // A phase length of zero behaves as one tick.
    function automatic int hold_now();
        return (eng_len == '0) ? 1 : int'(eng_len);
    endfunction

    // Advances the predicted engine by one tick and returns the pins and flags.
    function automatic out_item_t engine_tick(input in_item_t it);
        out_item_t r;
        logic      busy;
        logic      fin;
        busy = 1'b0;
        fin = 1'b0;
        if (eng_cmd == CMD_IDLE && it.kind >= 3'(CMD_START) && it.kind <= 3'(CMD_ACK)) begin
            eng_cmd = cmd_t'(it.kind);
            eng_step = '0;
            eng_count = '0;
            eng_shift = (eng_cmd == CMD_WRITE) ? it.data : 8'h00;
            cmds_begun[it.kind]++;
        end
        if (eng_cmd != CMD_IDLE) begin
            busy = 1'b1;
            if (eng_count == '0) begin
                case (eng_cmd)
                    CMD_START: begin
                        case (eng_step)
                            5'd0: eng_scl = 1'b1;
                            5'd1: begin eng_sda = 1'b1; eng_oe = 1'b1; end
                            5'd2: begin eng_sda = 1'b0; eng_oe = 1'b1; end
                            default: eng_scl = 1'b0;
                        endcase
                    end
                    CMD_STOP: begin
                        case (eng_step)
                            5'd0: begin eng_sda = 1'b0; eng_oe = 1'b1; end
                            5'd1: eng_scl = 1'b1;
                            default: begin eng_sda = 1'b1; eng_oe = 1'b1; end
                        endcase
                    end
                    CMD_WRITE: begin
                        if (eng_step >= 5'd24 || eng_step % 3 == 0) begin
                            eng_scl = 1'b0;
                        end else if (eng_step % 3 == 1) begin
                            eng_sda = eng_shift[7];
                            eng_oe = 1'b1;
                            eng_shift = eng_shift << 1;
                        end else begin
                            eng_scl = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (eng_step == 5'd0) begin
                            eng_scl = 1'b0;
                        end else if (eng_step == 5'd1) begin
                            eng_sda = 1'b1;
                            eng_oe = 1'b0;
                        end else begin
                            eng_scl = ~eng_step[0];
                        end
                    end
                    CMD_ACK: begin
                        case (eng_step)
                            5'd0: eng_scl = 1'b0;
                            5'd1: begin eng_sda = 1'b1; eng_oe = 1'b1; end
                            5'd2: begin eng_oe = 1'b0; eng_scl = 1'b1; end
                            5'd4: eng_scl = 1'b0;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (int'(eng_count) + 1 >= hold_now()) begin
                // SDA is sampled on the last tick of the SCL-high phase of a read bit or ack.
                if (eng_cmd == CMD_READ && eng_step >= 5'd2 && eng_step <= 5'd16
                        && !eng_step[0])
                    eng_shift = {eng_shift[6:0], it.sda_in};
                else if (eng_cmd == CMD_ACK && eng_step == 5'd2)
                    eng_nack = it.sda_in;
                eng_count = '0;
                eng_step = eng_step + 5'd1;
                if (int'(eng_step) >= phases_of(eng_cmd)) begin
                    if (eng_cmd == CMD_READ)
                        eng_rd = eng_shift;
                    fin = 1'b1;
                    eng_cmd = CMD_IDLE;
                    eng_step = '0;
                end
            end else begin
                eng_count = eng_count + 16'd1;
            end
        end
        r.scl = eng_scl;
        r.sda_out = eng_sda;
        r.sda_drive = eng_oe;
        r.busy_res = busy;
        r.done_res = fin;
        r.read_byte = eng_rd;
        r.nack = eng_nack;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    task automatic queue_item(logic [2:0] kind, logic [7:0] data, logic sda);
        in_item_t it;
        it.kind = kind;
        it.data = data;
        it.sda_in = sda;
        tick_queue.push_back(it);
        items_queued++;
    endtask

    // One command followed by exactly enough ticks to complete it. Ticks after
    // the first may carry stray commands, which the busy engine must ignore.
    task automatic queue_cmd(cmd_t op, logic [7:0] byte_val, int sda_mode, int noise_pct);
        int         k;
        int         total;
        logic [2:0] kind;
        logic       bit_in;
        total = phases_of(op) * hold_now();
        for (k = 0; k < total; k++) begin
            if (k == 0)
                kind = op;
            else if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
                kind = 3'($urandom_range(1, 7));
            else
                kind = CMD_IDLE;
            case (sda_mode)
                SDA_LOW:  bit_in = 1'b0;
                SDA_HIGH: bit_in = 1'b1;
                default:  bit_in = 1'($urandom);
            endcase
            queue_item(kind, (k == 0) ? byte_val : 8'($urandom), bit_in);
        end
    endtask

    task automatic queue_idle(int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            queue_item(r == 0 ? KIND_SPARE_A : (r == 1 ? KIND_SPARE_B : 3'(CMD_IDLE)),
                       8'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_traffic(int quota);
        int   made;
        int   pick;
        int   n;
        cmd_t op;
        made = 0;
        while (made < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                op = CMD_START;
            else if (pick < 30)
                op = CMD_STOP;
            else if (pick < 60)
                op = CMD_WRITE;
            else if (pick < 85)
                op = CMD_READ;
            else
                op = CMD_ACK;
            pick = $urandom_range(0, 9);
            queue_cmd(op, 8'($urandom),
                      pick == 0 ? SDA_LOW : (pick == 1 ? SDA_HIGH : SDA_RAND),
                      pick >= 8 ? 15 : 0);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            queue_idle(n);
            made += phases_of(op) * hold_now() + n;
        end
    endtask

    // Returns at a falling edge once every tick has been taken, every result
    // has arrived and the engine has finished its command.
    task automatic settle();
        int left;
        forever begin
            @(negedge aclk);
            if (items_taken == items_queued && pins_due.size() == 0) begin
                if (eng_cmd == CMD_IDLE)
                    break;
                left = (phases_of(eng_cmd) - int'(eng_step)) * hold_now() - int'(eng_count);
                queue_idle(left);
            end
        end
    endtask

    task automatic set_phase_len(logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        eng_len = value;
    endtask

    // Driver: presents queued ticks, holding each until it is taken.
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (aresetn && tick_queue.size() != 0) begin
                s_item <= tick_queue.pop_front();
                s_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
        s_took = 1'b0;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Monitor: predicts on every accepted tick and checks every result item.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pins_due.push_back(engine_tick(s_item));
                s_took = 1'b1;
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (pins_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_item);
                end else begin
                    want = pins_due.pop_front();
                    check_field("scl", 8'(want.scl), 8'(m_item.scl));
                    check_field("sda_out", 8'(want.sda_out), 8'(m_item.sda_out));
                    check_field("sda_drive", 8'(want.sda_drive), 8'(m_item.sda_drive));
                    check_field("busy_res", 8'(want.busy_res), 8'(m_item.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(m_item.done_res));
                    check_field("read_byte", want.read_byte, m_item.read_byte);
                    check_field("nack", 8'(want.nack), 8'(m_item.nack));
                    results_seen++;
                end
            end
        end
    end

    initial begin : stimulus
        int ph;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Plain ticks and the two unused kinds while idle, then start, write,
        // acknowledge and read with the extremes of data and of the sampled SDA level.
        queue_item(CMD_IDLE, 8'h00, 1'b0);
        queue_item(CMD_IDLE, 8'hFF, 1'b1);
        queue_item(KIND_SPARE_A, 8'h5A, 1'b0);
        queue_item(KIND_SPARE_B, 8'hA5, 1'b1);
        queue_cmd(CMD_START, 8'h00, SDA_RAND, 0);
        queue_cmd(CMD_WRITE, 8'hFF, SDA_RAND, 0);
        queue_cmd(CMD_ACK, 8'h00, SDA_LOW, 0);
        queue_cmd(CMD_WRITE, 8'h00, SDA_RAND, 0);
        queue_cmd(CMD_ACK, 8'hFF, SDA_HIGH, 0);
        queue_cmd(CMD_READ, 8'h00, SDA_HIGH, 0);
        queue_cmd(CMD_READ, 8'hFF, SDA_LOW, 0);
        // Every tick after the first of this start carries a stray kind to be ignored.
        queue_cmd(CMD_START, 8'h00, SDA_RAND, 100);
        queue_cmd(CMD_READ, 8'h3C, SDA_RAND, 0);
        queue_cmd(CMD_STOP, 8'h00, SDA_RAND, 0);

        set_phase_len(16'd0);
        queue_cmd(CMD_START, 8'h00, SDA_RAND, 0);
        queue_cmd(CMD_WRITE, 8'hA5, SDA_RAND, 0);
        queue_cmd(CMD_ACK, 8'h00, SDA_RAND, 0);
        queue_cmd(CMD_READ, 8'h00, SDA_RAND, 0);

        // A longer phase length on a single stop, sent with no gaps or stalls.
        set_phase_len(16'd37);
        idling_on = 1'b0;
        queue_cmd(CMD_STOP, 8'h00, SDA_RAND, 0);

        for (ph = 0; ph < 4; ph++) begin
            set_phase_len(ph == 3 ? 16'($urandom_range(1, 5)) : 16'(ph + 1));
            idling_on = (ph != 2);
            random_traffic(280);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (pins_due.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results expected but never seen", $time, pins_due.size());
        end
        $display("Sent %0d ticks and checked %0d results at phase lengths 0 to 3, 37 and 1 to 5.",
                 items_taken, results_seen);
        $display("Commands begun: start %0d, stop %0d, write %0d, read %0d, ack check %0d.",
                 cmds_begun[CMD_START], cmds_begun[CMD_STOP], cmds_begun[CMD_WRITE],
                 cmds_begun[CMD_READ], cmds_begun[CMD_ACK]);
        if (fail_count == 0)
            $display("i2c_master_bit_engine test passed");
        else
            $display("i2c_master_bit_engine test failed");
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("i2c_master_bit_engine test failed");
        $finish;
    end

endmodule

[filelist.f]
src/i2cmbe_pkg.sv
src/i2cmbe_engine.sv
src/i2c_master_bit_engine.sv
bench/i2c_master_bit_engine_tb.sv
